### src/tsd_pkg.sv
// Shared types and constants for the tar stream header deframer.
`timescale 1ns / 1ps

package tsd_pkg;

  // Archive framing
  localparam int BLOCK_BYTES      = 512;
  localparam int BLOCK_LOG2       = $clog2(BLOCK_BYTES);
  localparam int HDR_IDX_W        = BLOCK_LOG2;
  localparam int SIZE_FIELD_FIRST = 124;
  localparam int SIZE_FIELD_LAST  = 135;
  localparam int TYPE_FIELD       = 156;
  localparam int POSITION_BITS_DEF = 40;

  // Field widths
  localparam int BYTE_W        = 8;
  localparam int STATUS_W      = 3;
  localparam int ENTRY_SIZE_W  = 36;
  localparam int SKIP_W        = 37;
  localparam int DATA_OFFSET_W = 40;
  localparam int OUT_TDATA_W   = 80;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 2;

  // Type flag characters
  localparam logic [BYTE_W-1:0] TYPE_FILE = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] TYPE_DIR  = 8'h35;  // '5'

  typedef enum logic [STATUS_W-1:0] {
    ST_FILE      = 3'd0,
    ST_DIR       = 3'd1,
    ST_ZERO_END  = 3'd2,
    ST_INPUT_END = 3'd3,
    ST_TRUNCATED = 3'd4,
    ST_BAD_TYPE  = 3'd5
  } status_t;

  // Size field parse state
  typedef enum logic [2:0] {
    PH_BLANK = 3'b001,
    PH_DIGIT = 3'b010,
    PH_STOP  = 3'b100
  } size_phase_t;

  // One classified beat, handed from the front to the back
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              start;
    logic              blank;
    logic              digit;
    logic              nonzero;
  } tsd_item_t;

endpackage

### src/tsd_front.sv
// Input side: classifies each byte and queues it for the parser.
`timescale 1ns / 1ps

module tsd_front
  import tsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] in_tdata,
  input  logic              in_tlast,
  input  logic              in_tuser,
  input  logic              in_tvalid,
  output logic              in_tready,
  output tsd_item_t         item,
  output logic              item_valid,
  input  logic              item_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);

  tsd_item_t        q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  tsd_item_t        cls;
  logic             push;
  logic             pop;

  // Classify the incoming byte
  always_comb begin
    cls.data    = in_tdata;
    cls.last    = in_tlast;
    cls.start   = in_tuser;
    cls.blank   = (in_tdata == 8'h20) || (in_tdata inside {[8'h09:8'h0D]});
    cls.digit   = in_tdata inside {[8'h30:8'h37]};
    cls.nonzero = |in_tdata;
  end

  assign in_tready  = (cnt_r != CNT_FULL);
  assign item_valid = (cnt_r != '0);
  assign item       = q_r[rd_ptr_r];
  assign push       = in_tvalid && in_tready;
  assign pop        = item_pop && item_valid;

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

### src/tsd_back.sv
// Parser side: header walk, size decode, data skip and the result register.
`timescale 1ns / 1ps

module tsd_back
  import tsd_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tsd_item_t                item,
  input  logic                     item_valid,
  output logic                     item_pop,
  output logic [OUT_TDATA_W-1:0]   out_tdata,
  output logic                     out_tlast,
  output logic                     out_tvalid,
  input  logic                     out_tready
);

  localparam logic [HDR_IDX_W-1:0] IDX_SIZE_FIRST = HDR_IDX_W'(SIZE_FIELD_FIRST);
  localparam logic [HDR_IDX_W-1:0] IDX_SIZE_LAST  = HDR_IDX_W'(SIZE_FIELD_LAST);
  localparam logic [HDR_IDX_W-1:0] IDX_TYPE       = HDR_IDX_W'(TYPE_FIELD);
  localparam logic [HDR_IDX_W-1:0] IDX_LAST       = HDR_IDX_W'(BLOCK_BYTES - 1);
  localparam int PAD_W = OUT_TDATA_W - STATUS_W - ENTRY_SIZE_W - DATA_OFFSET_W;

  // Parse state
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, pos_e;
  logic [HDR_IDX_W-1:0]     hidx_r, hidx_nxt, hidx_e;
  logic [SKIP_W-1:0]        skip_r, skip_nxt, skip_e;
  logic [ENTRY_SIZE_W-1:0]  acc_r, acc_nxt, acc_e;
  size_phase_t              phase_r, phase_nxt, phase_e;
  logic [BYTE_W-1:0]        type_r, type_nxt, type_e;
  logic                     allz_r, allz_nxt, allz_e;
  logic                     zcnt_r, zcnt_nxt, zcnt_e;
  logic                     done_r, done_nxt, done_e;

  // Result register
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r;
  logic [ENTRY_SIZE_W-1:0]  out_size_r;
  logic [DATA_OFFSET_W-1:0] out_off_r;
  logic                     out_fin_r;

  logic                     res_valid;
  status_t                  res_status;
  logic [ENTRY_SIZE_W-1:0]  res_size;
  logic [DATA_OFFSET_W-1:0] res_off;
  logic                     res_fin;
  logic [SKIP_W-1:0]        round_sum;
  logic [POSITION_BITS+DATA_OFFSET_W-1:0] pos_ext;
  logic                     pop;

  // Take a beat when the result slot is free or draining
  assign pop      = item_valid && (!out_valid_r || out_tready);
  assign item_pop = pop;

  // A start beat sees freshly cleared state
  always_comb begin
    if (item.start) begin
      pos_e   = '0;
      hidx_e  = '0;
      skip_e  = '0;
      acc_e   = '0;
      phase_e = PH_BLANK;
      type_e  = '0;
      allz_e  = 1'b1;
      zcnt_e  = 1'b0;
      done_e  = 1'b0;
    end else begin
      pos_e   = pos_r;
      hidx_e  = hidx_r;
      skip_e  = skip_r;
      acc_e   = acc_r;
      phase_e = phase_r;
      type_e  = type_r;
      allz_e  = allz_r;
      zcnt_e  = zcnt_r;
      done_e  = done_r;
    end
  end

  // Data size rounded up to whole blocks
  always_comb begin
    round_sum = {1'b0, acc_e} + SKIP_W'(BLOCK_BYTES - 1);
  end

  assign pos_ext = {{DATA_OFFSET_W{1'b0}}, pos_nxt};

  // Per-byte parse step
  always_comb begin
    pos_nxt    = pos_r;
    hidx_nxt   = hidx_r;
    skip_nxt   = skip_r;
    acc_nxt    = acc_r;
    phase_nxt  = phase_r;
    type_nxt   = type_r;
    allz_nxt   = allz_r;
    zcnt_nxt   = zcnt_r;
    done_nxt   = done_r;
    res_valid  = 1'b0;
    res_status = ST_INPUT_END;
    res_size   = '0;
    res_off    = '0;
    res_fin    = 1'b0;

    if (pop) begin
      pos_nxt   = pos_e;
      hidx_nxt  = hidx_e;
      skip_nxt  = skip_e;
      acc_nxt   = acc_e;
      phase_nxt = phase_e;
      type_nxt  = type_e;
      allz_nxt  = allz_e;
      zcnt_nxt  = zcnt_e;
      done_nxt  = done_e;

      if (!done_e) begin
        pos_nxt = pos_e + 1'b1;
        if (skip_e != '0) begin
          // data area
          skip_nxt = skip_e - 1'b1;
          if (item.last) begin
            res_valid  = 1'b1;
            res_status = ST_INPUT_END;
          end
        end else begin
          // header byte
          if (item.nonzero) begin
            allz_nxt = 1'b0;
          end
          if (hidx_e >= IDX_SIZE_FIRST && hidx_e <= IDX_SIZE_LAST) begin
            case (phase_e)
              PH_BLANK: begin
                if (!item.blank) begin
                  phase_nxt = item.digit ? PH_DIGIT : PH_STOP;
                end
              end
              PH_DIGIT: begin
                if (!item.digit) begin
                  phase_nxt = PH_STOP;
                end
              end
              PH_STOP: phase_nxt = PH_STOP;
              default: phase_nxt = PH_STOP;
            endcase
            if (phase_nxt == PH_DIGIT) begin
              acc_nxt = {acc_e[ENTRY_SIZE_W-4:0], 3'b000}
                        + {{(ENTRY_SIZE_W-3){1'b0}}, item.data[2:0]};
            end
          end
          if (hidx_e == IDX_TYPE) begin
            type_nxt = item.data;
          end
          if (hidx_e == IDX_LAST) begin
            // end of header block
            if (allz_nxt) begin
              zcnt_nxt = 1'b1;
              if (zcnt_e) begin
                res_valid  = 1'b1;
                res_status = ST_ZERO_END;
              end else if (item.last) begin
                res_valid  = 1'b1;
                res_status = ST_INPUT_END;
              end
            end else if (type_e == TYPE_FILE || type_e == TYPE_DIR) begin
              res_valid  = 1'b1;
              res_status = (type_e == TYPE_FILE) ? ST_FILE : ST_DIR;
              res_size   = acc_e;
              res_off    = pos_ext[DATA_OFFSET_W-1:0];
              skip_nxt   = {round_sum[SKIP_W-1:BLOCK_LOG2], {BLOCK_LOG2{1'b0}}};
            end else begin
              res_valid  = 1'b1;
              res_status = ST_BAD_TYPE;
            end
            hidx_nxt  = '0;
            acc_nxt   = '0;
            phase_nxt = PH_BLANK;
            type_nxt  = '0;
            allz_nxt  = 1'b1;
          end else begin
            hidx_nxt = hidx_e + 1'b1;
            if (item.last) begin
              res_valid  = 1'b1;
              res_status = ST_TRUNCATED;
            end
          end
        end
        if (res_valid) begin
          res_fin = item.last || (res_status != ST_FILE && res_status != ST_DIR);
          if (res_fin) begin
            done_nxt = 1'b1;
          end
        end
      end
    end
  end

  // Result slot valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = res_valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      hidx_r      <= '0;
      skip_r      <= '0;
      acc_r       <= '0;
      phase_r     <= PH_BLANK;
      type_r      <= '0;
      allz_r      <= 1'b1;
      zcnt_r      <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      hidx_r      <= hidx_nxt;
      skip_r      <= skip_nxt;
      acc_r       <= acc_nxt;
      phase_r     <= phase_nxt;
      type_r      <= type_nxt;
      allz_r      <= allz_nxt;
      zcnt_r      <= zcnt_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_status_r <= res_status;
      out_size_r   <= res_size;
      out_off_r    <= res_off;
      out_fin_r    <= res_fin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_fin_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_off_r, out_size_r, out_status_r};

endmodule

### src/tar_stream_header_deframer.sv
// Top level of the tar stream header deframer.
`timescale 1ns / 1ps

// Takes a tar archive one byte per beat and reports result beats for its headers:
// file or directory entries with their octal size and the stream offset of
// their data, the end of the archive, truncation or an unsupported type.
// The block takes one byte per clock cycle, sustained, as long as results
// are drained; a result is registered when the parser takes the header's
// last byte from the queue. The parser handles one byte per cycle while its
// result register is free or draining; a two-beat queue between the input
// classifier and the parser and the result register let either side stall
// alone. After a final result (out_tlast high) further bytes are dropped
// until a beat with in_tuser set restarts parsing at offset zero.

module tar_stream_header_deframer
  import tsd_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: [7:0] stream_byte; in_tlast: is_last
  input  logic [BYTE_W-1:0]      in_tdata,
  input  logic                   in_tlast,
  // in_tuser: [0] start_archive
  input  logic                   in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // out_tdata: [2:0] status, [38:3] entry_size, [78:39] data_offset, [79] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tlast: final_res
  output logic                   out_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready
);

  tsd_item_t item;
  logic      item_valid;
  logic      item_pop;

  tsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  tsd_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // Any result other than an entry ends parsing
  a_nonentry_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != ST_FILE && out_tdata[2:0] != ST_DIR |-> out_tlast)
    else $error("non-entry result without final flag");

  // Non-entry results carry no size or offset
  a_nonentry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != ST_FILE && out_tdata[2:0] != ST_DIR
      |-> out_tdata[OUT_TDATA_W-1:STATUS_W] == '0)
    else $error("non-entry result with size or offset");

  // Input only stalls while the queue holds beats
  a_stall_has_items: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> item_valid)
    else $error("input stalled with empty queue");

endmodule

### tb/sv/tar_stream_header_deframer_tb.sv
// Self-checking testbench for the tar stream header deframer.
`timescale 1ns / 1ps

module tar_stream_header_deframer_tb;
  import tsd_pkg::*;

  localparam int CLK_HALF_NS        = 6;
  localparam int RESET_CYCLES       = 12;
  localparam int LIMIT_CYCLES       = 2_000_000;
  localparam int TAIL_CYCLES        = 16;
  localparam int ZERO_BLOCKS_TO_END = 2;
  localparam int BIG_SKIP           = 2048;
  localparam int MAX_PRINTED        = 40;

  // Result field offsets inside out_tdata
  localparam int OFS_SIZE   = STATUS_W;
  localparam int OFS_OFFSET = STATUS_W + ENTRY_SIZE_W;

  // Characters the size field parser cares about
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_SEVEN = 8'h37;
  localparam logic [BYTE_W-1:0] CH_EIGHT = 8'h38;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_BADT  = 8'h78;

  typedef struct {
    status_t                  status;
    logic [ENTRY_SIZE_W-1:0]  entry_size;
    logic [DATA_OFFSET_W-1:0] data_offset;
    logic                     last_res;
  } deframe_result_t;

  logic                   clk;
  logic                   rst_n;
  logic [BYTE_W-1:0]      in_tdata;
  logic                   in_tlast;
  logic                   in_tuser;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;

  // Predictor state
  logic [DATA_OFFSET_W-1:0] pos;
  logic [HDR_IDX_W-1:0]     hdr_idx;
  logic [SKIP_W-1:0]        skip_left;
  logic [ENTRY_SIZE_W-1:0]  size_acc;
  size_phase_t              size_ph;
  logic [BYTE_W-1:0]        type_ch;
  bit                       hdr_zero;
  int                       zero_blocks;
  bit                       arch_done;

  deframe_result_t   exp_results[$];
  logic [BYTE_W-1:0] hdr_img [BLOCK_BYTES];

  int n_errors       = 0;
  int n_sent         = 0;
  int n_predicted    = 0;
  int cycle_cnt      = 0;
  int hold_left      = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  tar_stream_header_deframer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),    // [7:0] stream_byte
    .in_tlast   (in_tlast),    // is_last
    .in_tuser   (in_tuser),    // [0] start_archive
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),   // status, entry_size, data_offset, zero pad
    .out_tlast  (out_tlast),   // final_res
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF_NS clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic clear_header();
    hdr_idx  = '0;
    size_acc = '0;
    size_ph  = PH_BLANK;
    type_ch  = '0;
    hdr_zero = 1'b1;
  endtask

  task automatic clear_archive();
    pos         = '0;
    skip_left   = '0;
    zero_blocks = 0;
    arch_done   = 1'b0;
    clear_header();
  endtask

  // One byte of the size field: skip blanks, take octal digits, stop at anything else
  task automatic octal_size_step(input logic [BYTE_W-1:0] b);
    bit dig;
    dig = (b >= CH_ZERO) && (b <= CH_SEVEN);
    if (size_ph == PH_BLANK) begin
      if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) return;
      if (dig) size_ph = PH_DIGIT;
      else size_ph = PH_STOP;
    end else if (size_ph == PH_DIGIT && !dig) begin
      size_ph = PH_STOP;
    end
    if (size_ph == PH_DIGIT) size_acc = {size_acc[ENTRY_SIZE_W-4:0], b[2:0]};
  endtask

  // Advance the parse by one accepted byte and queue what it produces
  task automatic deframe_byte(input logic [BYTE_W-1:0] b, input bit last, input bit start);
    bit                       have;
    status_t                  st;
    logic [ENTRY_SIZE_W-1:0]  esz;
    logic [DATA_OFFSET_W-1:0] eoff;
    deframe_result_t          r;
    have = 1'b0;
    st   = ST_FILE;
    esz  = '0;
    eoff = '0;
    if (start) clear_archive();
    if (arch_done) return;
    pos = pos + 1'b1;
    if (skip_left != '0) begin
      skip_left = skip_left - 1'b1;
      if (last) begin
        have = 1'b1;
        st   = ST_INPUT_END;
      end
    end else begin
      if (b != '0) hdr_zero = 1'b0;
      if (hdr_idx >= SIZE_FIELD_FIRST && hdr_idx <= SIZE_FIELD_LAST) octal_size_step(b);
      if (hdr_idx == TYPE_FIELD) type_ch = b;
      if (hdr_idx == BLOCK_BYTES - 1) begin
        have = 1'b1;
        if (hdr_zero) begin
          zero_blocks++;
          if (zero_blocks >= ZERO_BLOCKS_TO_END) st = ST_ZERO_END;
          else if (last) st = ST_INPUT_END;
          else have = 1'b0;
        end else if (type_ch == TYPE_FILE || type_ch == TYPE_DIR) begin
          if (type_ch == TYPE_FILE) st = ST_FILE;
          else st = ST_DIR;
          esz  = size_acc;
          eoff = pos;
          // data area rounded up to whole blocks
          skip_left = ({1'b0, size_acc} + SKIP_W'(BLOCK_BYTES - 1))
                      & ~SKIP_W'(BLOCK_BYTES - 1);
        end else begin
          st = ST_BAD_TYPE;
        end
        clear_header();
      end else begin
        hdr_idx = hdr_idx + 1'b1;
        if (last) begin
          have = 1'b1;
          st   = ST_TRUNCATED;
        end
      end
    end
    if (have) begin
      r.status      = st;
      r.entry_size  = esz;
      r.data_offset = eoff;
      r.last_res    = last || (st == ST_ZERO_END) || (st == ST_BAD_TYPE);
      if (r.last_res) arch_done = 1'b1;
      exp_results.push_back(r);
      n_predicted++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checking
  // ---------------------------------------------------------------------------

  task automatic report_error(input string msg);
    n_errors++;
    if (n_errors <= MAX_PRINTED) $display("ERROR [%0t] %s", $time, msg);
  endtask

  // Receiver ready: long hold-off when requested, else random stalls if enabled
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (recv_stall_pct != 0) begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    deframe_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_results.size() == 0) begin
        report_error($sformatf("result beat with none expected: tdata=%h tlast=%b",
                               out_tdata, out_tlast));
      end else begin
        want = exp_results.pop_front();
        if (out_tdata[STATUS_W-1:0] !== want.status)
          report_error($sformatf("status got %0d exp %0d",
                                 out_tdata[STATUS_W-1:0], want.status));
        if (out_tdata[OFS_SIZE +: ENTRY_SIZE_W] !== want.entry_size)
          report_error($sformatf("entry_size got %0d exp %0d",
                                 out_tdata[OFS_SIZE +: ENTRY_SIZE_W], want.entry_size));
        if (out_tdata[OFS_OFFSET +: DATA_OFFSET_W] !== want.data_offset)
          report_error($sformatf("data_offset got %0d exp %0d",
                                 out_tdata[OFS_OFFSET +: DATA_OFFSET_W], want.data_offset));
        if (out_tdata[OUT_TDATA_W-1] !== 1'b0)
          report_error("pad bit of out_tdata not zero");
        if (out_tlast !== want.last_res)
          report_error($sformatf("final flag got %b exp %b", out_tlast, want.last_res));
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one beat, wait for the handshake, then update the prediction
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit last, input bit start);
    int gap;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(3, 1);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    n_sent++;
    deframe_byte(b, last, start);
  endtask

  task automatic send_run(input int n, input bit start, input bit last_at_end);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom), last_at_end && (i == n - 1), start && (i == 0));
  endtask

  // Send the header image; cut >= 0 ends the stream on that byte
  task automatic send_block(input bit start, input int cut);
    int n;
    n = (cut < 0) ? BLOCK_BYTES : cut + 1;
    for (int i = 0; i < n; i++) send_byte(hdr_img[i], i == cut, start && (i == 0));
  endtask

  function automatic logic [BYTE_W-1:0] blank_char(input int k);
    case (k)
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return 8'h0A;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return CH_CR;
    endcase
  endfunction

  // Build a header: nb blanks, the low nd octal digits of v, then term
  task automatic fill_header(input logic [BYTE_W-1:0] t, input logic [ENTRY_SIZE_W-1:0] v,
                             input int nd, input int nb, input logic [BYTE_W-1:0] term,
                             input bit noisy);
    int p;
    for (int i = 0; i < BLOCK_BYTES; i++) hdr_img[i] = noisy ? 8'($urandom) : 8'h00;
    p = SIZE_FIELD_FIRST;
    for (int j = 0; j < nb && p <= SIZE_FIELD_LAST; j++) begin
      hdr_img[p] = blank_char($urandom_range(5));
      p++;
    end
    for (int d = nd - 1; d >= 0 && p <= SIZE_FIELD_LAST; d--) begin
      hdr_img[p] = CH_ZERO | {5'b0, v[3*d +: 3]};
      p++;
    end
    if (p <= SIZE_FIELD_LAST) hdr_img[p] = term;
    hdr_img[TYPE_FIELD] = t;
  endtask

  task automatic send_zero_block(input bit start, input int cut);
    fill_header(8'h00, '0, 0, 0, 8'h00, 1'b0);
    send_block(start, cut);
  endtask

  // Random entry header, or one with an unsupported type
  task automatic random_header(input bit bad);
    logic [BYTE_W-1:0]       t;
    logic [BYTE_W-1:0]       term;
    logic [ENTRY_SIZE_W-1:0] v;
    int                      nd;
    int                      pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      v  = '0;
      nd = $urandom_range(11, 0);
    end else if (pick < 90) begin
      v  = ENTRY_SIZE_W'($urandom_range(1100, 1));
      nd = 4;
    end else begin
      v  = {4'($urandom), 32'($urandom)};
      nd = $urandom_range(12, 5);
    end
    case ($urandom_range(5))
      0:       term = 8'h00;
      1:       term = CH_SPACE;
      2:       term = CH_PLUS;
      3:       term = CH_MINUS;
      4:       term = CH_EIGHT;
      default: term = 8'($urandom);
    endcase
    if (bad) begin
      t = 8'($urandom);
      while (t == TYPE_FILE || t == TYPE_DIR) t = 8'($urandom);
    end else if ($urandom_range(1) == 1) begin
      t = TYPE_FILE;
    end else begin
      t = TYPE_DIR;
    end
    fill_header(t, v, nd, ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0, term,
                $urandom_range(1));
  endtask

  // Sender pauses until every expected result beat has arrived
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Archive straight after reset, no restart flag: file, directory, two zero blocks
  task automatic test_plain_archive();
    fill_header(TYPE_FILE, '0, 11, 0, 8'h00, 1'b0);
    send_block(1'b0, -1);
    fill_header(TYPE_DIR, '0, 11, 0, CH_SPACE, 1'b1);
    send_block(1'b0, -1);
    send_zero_block(1'b0, -1);
    send_zero_block(1'b0, -1);
    // dropped after the end
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b0);
  endtask

  // Size field parsing: blanks, signs, non-octal stop, full 12 digits
  task automatic test_size_field();
    // every blank kind ahead of "17", stopped by a plus sign
    fill_header(TYPE_FILE, ENTRY_SIZE_W'('o17), 2, 6, CH_PLUS, 1'b0);
    for (int j = 0; j < 6; j++) hdr_img[SIZE_FIELD_FIRST + j] = blank_char(j);
    send_block(1'b1, -1);
    send_run(int'(skip_left), 1'b0, 1'b0);
    // minus sign first: size stays zero
    fill_header(TYPE_DIR, '0, 0, 0, CH_MINUS, 1'b0);
    hdr_img[SIZE_FIELD_FIRST + 1] = CH_ZERO + 8'd5;
    send_block(1'b0, -1);
    // digits stopped by a minus sign
    fill_header(TYPE_FILE, ENTRY_SIZE_W'('o12), 2, 0, CH_MINUS, 1'b1);
    send_block(1'b0, -1);
    send_run(int'(skip_left), 1'b0, 1'b0);
    // non-octal digit first
    fill_header(TYPE_FILE, '0, 0, 0, CH_EIGHT, 1'b1);
    send_block(1'b0, -1);
    // field of blanks only
    fill_header(TYPE_DIR, '0, 0, 12, 8'h00, 1'b0);
    send_block(1'b0, -1);
    // exactly one block of data
    fill_header(TYPE_FILE, ENTRY_SIZE_W'('o1000), 4, 1, 8'h00, 1'b0);
    send_block(1'b0, -1);
    send_run(int'(skip_left), 1'b0, 1'b0);
    // largest size, stream ends in its data
    fill_header(TYPE_DIR, '1, 12, 0, 8'h00, 1'b1);
    send_block(1'b0, -1);
    send_run(3, 1'b0, 1'b1);
  endtask

  // Zero block counting and ends on the last byte of a header
  task automatic test_zero_blocks();
    // count survives an entry between zero blocks
    send_zero_block(1'b1, -1);
    fill_header(TYPE_FILE, '0, 1, 0, 8'h00, 1'b1);
    send_block(1'b0, -1);
    send_zero_block(1'b0, -1);
    // first zero block ends on the final byte
    send_zero_block(1'b1, BLOCK_BYTES - 1);
    // entry header ends on the final byte
    fill_header(TYPE_FILE, ENTRY_SIZE_W'('o7), 1, 0, 8'h00, 1'b1);
    send_block(1'b1, BLOCK_BYTES - 1);
  endtask

  // Streams that end inside a header or inside data
  task automatic test_truncation();
    send_byte(8'h5A, 1'b1, 1'b1);
    send_run(300, 1'b1, 1'b1);
    // end on the byte right after a header with no data
    fill_header(TYPE_FILE, '0, 3, 0, 8'h00, 1'b0);
    send_block(1'b1, -1);
    send_byte(8'h00, 1'b1, 1'b0);
    // end part way through the data
    fill_header(TYPE_FILE, ENTRY_SIZE_W'('o144), 3, 0, 8'h00, 1'b0);
    send_block(1'b1, -1);
    send_run(100, 1'b0, 1'b1);
    // end on the last data byte
    fill_header(TYPE_DIR, ENTRY_SIZE_W'(1), 1, 0, 8'h00, 1'b1);
    send_block(1'b1, -1);
    send_run(int'(skip_left), 1'b0, 1'b1);
    // end one byte short of a full header
    random_header(1'b0);
    send_block(1'b1, BLOCK_BYTES - 2);
  endtask

  // Unsupported types and restart in the middle of a header
  task automatic test_bad_type();
    fill_header(CH_BADT, '0, 2, 0, 8'h00, 1'b1);
    send_block(1'b1, -1);
    send_run(5, 1'b0, 1'b1);
    // NUL type on a header that is not all zero
    fill_header(8'h00, ENTRY_SIZE_W'(7), 1, 0, 8'h00, 1'b0);
    send_block(1'b1, -1);
    // restart part way through a header
    send_run(200, 1'b1, 1'b0);
    fill_header(TYPE_FILE, '0, 2, 0, 8'h00, 1'b1);
    send_block(1'b1, -1);
    send_run(2, 1'b0, 1'b1);
  endtask

  // Long receiver hold-off while one-byte archives keep coming
  task automatic test_backpressure();
    hold_left = 400;
    for (int i = 0; i < 40; i++) send_byte(8'($urandom), 1'b1, 1'b1);
    drain_results();
  endtask

  // One random archive, mostly well formed
  task automatic random_archive();
    int pick;
    int n_ent;
    bit first;
    pick  = $urandom_range(99);
    first = 1'b1;
    if (pick < 25) begin
      // cut short, mostly inside the first header
      if (pick < 3) send_run($urandom_range(700, 400), 1'b1, 1'b1);
      else send_run($urandom_range(40, 1), 1'b1, 1'b1);
    end else if (pick < 35) begin
      // noise with random restarts and ends
      repeat ($urandom_range(30, 1))
        send_byte(8'($urandom), $urandom_range(9) == 0, $urandom_range(9) == 0);
    end else begin
      n_ent = $urandom_range(3, 0);
      for (int e = 0; e < n_ent && !arch_done; e++) begin
        random_header($urandom_range(99) < 4);
        send_block(first, -1);
        first = 1'b0;
        if (skip_left > BIG_SKIP) send_run($urandom_range(20, 1), 1'b0, 1'b1);
        else send_run(int'(skip_left), 1'b0, 1'b0);
      end
      if (!arch_done) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          send_zero_block(first, -1);
          if ($urandom_range(9) == 0) begin
            fill_header(TYPE_DIR, '0, 0, 0, 8'h00, 1'b1);
            send_block(1'b0, -1);
          end
          send_zero_block(1'b0, -1);
        end else if (pick < 65) begin
          send_zero_block(first, BLOCK_BYTES - 1);
        end else if (pick < 78) begin
          send_run($urandom_range(5, 1), first, 1'b1);
        end else if (pick < 90) begin
          random_header(1'b0);
          send_block(first, $urandom_range(BLOCK_BYTES - 1, 0));
        end else begin
          random_header(1'b1);
          send_block(first, -1);
        end
      end
    end
    // bytes after the end are dropped
    if (arch_done)
      repeat ($urandom_range(3, 0)) send_byte(8'($urandom), $urandom_range(1), 1'b0);
  endtask

  // Random archives under each idling pattern
  task automatic test_random();
    int base_res;
    int base_items;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      base_res   = n_predicted;
      base_items = n_sent;
      while (n_predicted - base_res < 16 || n_sent - base_items < 200) random_archive();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_archive();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    in_tuser  <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_archive();
    test_size_field();
    test_zero_blocks();
    test_truncation();
    test_bad_type();
    test_backpressure();
    test_random();

    drain_results();
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### tar_stream_header_deframer.f
src/tsd_pkg.sv
src/tsd_front.sv
src/tsd_back.sv
src/tar_stream_header_deframer.sv
tb/sv/tar_stream_header_deframer_tb.sv
